// ===== design/lww_element_set_table_assert.svh =====
// Assertion macros shared by the table RTL.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef LWW_ELEMENT_SET_TABLE_ASSERT_SVH
`define LWW_ELEMENT_SET_TABLE_ASSERT_SVH

// Same-cycle implication.
`define LWWST_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lwwst assertion failed");

// Next-cycle implication.
`define LWWST_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lwwst assertion failed");

`endif

// ===== design/lwwst_pkg.sv =====
`timescale 1ns / 1ps

package lwwst_pkg;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Operation token walking the cell row, one cell per cycle.
	typedef struct packed {
		logic        vld;
		logic [1:0]  kind;
		logic [31:0] key;
		logic [31:0] stamp;
		logic        a_hit;   // key present in added table after this op
		logic [31:0] a_time;  // added-table stamp of the key
		logic        r_hit;   // key found in removed table
		logic        a_free;  // a free added slot was seen
		logic        r_free;  // a free removed slot was seen
	} tok_t;

	// Insert write broadcast to all cells at the end of a pass.
	typedef struct packed {
		logic        a_en;
		logic        r_en;
		logic [31:0] key;
		logic [31:0] stamp;
	} wr_t;

endpackage

// ===== design/lwwst_cell.sv =====
`timescale 1ns / 1ps

module lwwst_cell
	import lwwst_pkg::*;
#(
	parameter int IDX_W = 4,
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tok_t             prev_tok,
	input  logic [IDX_W-1:0] prev_a_idx,
	input  logic [IDX_W-1:0] prev_r_idx,
	output tok_t             next_tok,
	output logic [IDX_W-1:0] next_a_idx,
	output logic [IDX_W-1:0] next_r_idx,
	input  wr_t              wr,
	input  logic [IDX_W-1:0] wr_idx
);

	logic        a_v_q, r_v_q;
	logic [31:0] a_key_q, a_time_q, r_key_q, r_time_q;
	logic        vld_q;
	tok_t        tok_q, tok_n;
	logic [IDX_W-1:0] a_idx_q, r_idx_q, a_idx_n, r_idx_n;

	logic a_match, r_match, a_raise, a_erase, r_raise, wr_here;
	logic is_add, is_rem;

	always_comb begin
		is_add  = prev_tok.vld && (prev_tok.kind == KIND_ADD);
		is_rem  = prev_tok.vld && (prev_tok.kind == KIND_REMOVE);
		a_match = a_v_q && (a_key_q == prev_tok.key);
		r_match = r_v_q && (r_key_q == prev_tok.key);
		a_raise = is_add && a_match && (a_time_q <= prev_tok.stamp);
		a_erase = is_rem && a_match && (a_time_q <= prev_tok.stamp);
		r_raise = is_rem && r_match && (r_time_q <= prev_tok.stamp);
		wr_here = (wr_idx == IDX_W'(INDEX));

		tok_n       = prev_tok;
		tok_n.a_hit = prev_tok.a_hit | (a_match & ~a_erase);
		if (a_match) begin
			tok_n.a_time = a_raise ? prev_tok.stamp : a_time_q;
		end
		tok_n.r_hit = prev_tok.r_hit | r_match;
		a_idx_n     = prev_a_idx;
		r_idx_n     = prev_r_idx;
		// first free slot along the row is the lowest one
		if (!prev_tok.a_free && !a_v_q) begin
			tok_n.a_free = 1'b1;
			a_idx_n      = IDX_W'(INDEX);
		end
		if (!prev_tok.r_free && !r_v_q) begin
			tok_n.r_free = 1'b1;
			r_idx_n      = IDX_W'(INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			r_v_q <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			vld_q <= prev_tok.vld;
			if (wr.a_en && wr_here) begin
				a_v_q <= 1'b1;
			end else if (a_erase) begin
				a_v_q <= 1'b0;
			end
			if (wr.r_en && wr_here) begin
				r_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q   <= tok_n;
		a_idx_q <= a_idx_n;
		r_idx_q <= r_idx_n;
		if (wr.a_en && wr_here) begin
			a_key_q  <= wr.key;
			a_time_q <= wr.stamp;
		end else if (a_raise) begin
			a_time_q <= prev_tok.stamp;
		end
		if (wr.r_en && wr_here) begin
			r_key_q  <= wr.key;
			r_time_q <= wr.stamp;
		end else if (r_raise) begin
			r_time_q <= prev_tok.stamp;
		end
	end

	always_comb begin
		next_tok     = tok_q;
		next_tok.vld = vld_q;
	end

	assign next_a_idx = a_idx_q;
	assign next_r_idx = r_idx_q;

endmodule

// ===== design/lww_element_set_table.sv =====
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_stall    kind, key, stamp
// out      out_valid / out_stall  present, held_stamp, status
//
// An operation walks the row of TABLE_DEPTH cells, one cell per cycle; each cell
// holds one added and one removed entry. The result is registered at the row end
// and then in the output register; in_stall stays high until that commit, so the
// next beat is taken only after the previous operation has left the row.
// Reset clears all valid bits at once; there is no clearing pass.
// A result held by out_stall does not block the next beat; a second finished
// result waits at the row end until the output register frees.

module lww_element_set_table
	import lwwst_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] key,
	input  logic [31:0] stamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        present,
	output logic [31:0] held_stamp,
	output logic        status
);

`include "lww_element_set_table_assert.svh"

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	tok_t             tok   [0:TABLE_DEPTH];
	logic [IDX_W-1:0] a_idx [0:TABLE_DEPTH];
	logic [IDX_W-1:0] r_idx [0:TABLE_DEPTH];
	logic [TABLE_DEPTH:0] chain_vld;

	logic             busy_q, fin_vld_q, out_valid_q;
	tok_t             fin_q;
	logic [IDX_W-1:0] fin_a_idx_q, fin_r_idx_q;
	logic             present_q, status_q;
	logic [31:0]      held_q;

	logic in_accept, commit, ins_a, ins_r, put_a, put_r, drop;
	wr_t  wr;
	logic [IDX_W-1:0] wr_idx;

	assign in_stall  = busy_q;
	assign in_accept = in_valid && !busy_q;

	always_comb begin
		tok[0]        = '0;
		tok[0].vld    = in_accept;
		tok[0].kind   = kind;
		tok[0].key    = key;
		tok[0].stamp  = stamp;
	end
	assign a_idx[0] = '0;
	assign r_idx[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lwwst_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_tok   (tok[i]),
			.prev_a_idx (a_idx[i]),
			.prev_r_idx (r_idx[i]),
			.next_tok   (tok[i+1]),
			.next_a_idx (a_idx[i+1]),
			.next_r_idx (r_idx[i+1]),
			.wr         (wr),
			.wr_idx     (wr_idx)
		);
		assign chain_vld[i] = tok[i+1].vld;
	end
	assign chain_vld[TABLE_DEPTH] = fin_vld_q;

	assign commit = fin_vld_q && (!out_valid_q || !out_stall);

	always_comb begin
		ins_a     = (fin_q.kind == KIND_ADD) && !fin_q.a_hit;
		ins_r     = (fin_q.kind == KIND_REMOVE) && !fin_q.r_hit;
		put_a     = ins_a && fin_q.a_free;
		put_r     = ins_r && fin_q.r_free;
		drop      = (ins_a && !fin_q.a_free) || (ins_r && !fin_q.r_free);
		wr.a_en   = commit && put_a;
		wr.r_en   = commit && put_r;
		wr.key    = fin_q.key;
		wr.stamp  = fin_q.stamp;
		wr_idx    = ins_a ? fin_a_idx_q : fin_r_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (tok[TABLE_DEPTH].vld) begin
				fin_vld_q <= 1'b1;
			end else if (commit) begin
				fin_vld_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[TABLE_DEPTH].vld) begin
			fin_q       <= tok[TABLE_DEPTH];
			fin_a_idx_q <= a_idx[TABLE_DEPTH];
			fin_r_idx_q <= r_idx[TABLE_DEPTH];
		end
		if (commit) begin
			present_q <= fin_q.a_hit || put_a;
			if (fin_q.a_hit) begin
				held_q <= fin_q.a_time;
			end else if (put_a) begin
				held_q <= fin_q.stamp;
			end else begin
				held_q <= '0;
			end
			status_q <= drop ? STATUS_FULL : STATUS_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign present    = present_q;
	assign held_stamp = held_q;
	assign status     = status_q;

	`LWWST_ASSERT(a_one_token, 1'b1, $countones(chain_vld) <= 1)
	`LWWST_ASSERT(a_token_busy, chain_vld != '0, busy_q)
	`LWWST_ASSERT(a_write_idle_row, wr.a_en || wr.r_en, chain_vld[TABLE_DEPTH-1:0] == '0)
	`LWWST_ASSERT_NXT(a_drop_absent, commit && ins_a && drop, !present_q && (held_q == '0))
	`LWWST_ASSERT_NXT(a_enter_row, in_accept, chain_vld[0] && busy_q)

endmodule
